[rtl/core/aes128_pkg.sv]
package aes128_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [127:0] blk_t;

	localparam int NumRounds = 10;

	// settle countdown start value, loaded after reset or a key write while the round key chain refills
	localparam logic [3:0] KeySettle = 4'(NumRounds + 1);

	typedef enum logic [0:0] {
		CMD_ENC = 1'b0,
		CMD_DEC = 1'b1
	} cmd_t;

	typedef enum logic [0:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} reg_idx_t;

	localparam byte_t SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	localparam byte_t RCON [10] = '{8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};

	localparam byte_t ISBOX [256] = '{
	8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
	8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
	8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
	8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
	8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
	8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
	8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
	8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
	8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
	8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
	8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
	8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
	8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
	8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
	8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
	8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

	function automatic byte_t xt(input byte_t b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i of the block sits in bits 127-8i .. 120-8i
	function automatic byte_t get_b(input blk_t s, input int i);
		return s[127 - 8 * i -: 8];
	endfunction

	function automatic blk_t sub_shift(input blk_t s, input logic inv);
		blk_t t;
		t = '0;
		for (int i = 0; i < 16; i++) begin
			if (inv) t[127 - 8 * i -: 8] = ISBOX[get_b(s, (13 * i) & 15)];
			else     t[127 - 8 * i -: 8] = SBOX[get_b(s, (5 * i) & 15)];
		end
		return t;
	endfunction

	function automatic blk_t mix(input blk_t s, input logic inv);
		blk_t t;
		byte_t a0, a1, a2, a3, u, v;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = get_b(s, 4 * c);
			a1 = get_b(s, 4 * c + 1);
			a2 = get_b(s, 4 * c + 2);
			a3 = get_b(s, 4 * c + 3);
			// inverse = premultiply by {04,00,05,00} then forward mix
			if (inv) begin
				u = xt(xt(a0 ^ a2));
				v = xt(xt(a1 ^ a3));
				a0 = a0 ^ u;
				a1 = a1 ^ v;
				a2 = a2 ^ u;
				a3 = a3 ^ v;
			end
			t[127 - 32 * c -: 8]      = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
			t[127 - 32 * c - 8 -: 8]  = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
			t[127 - 32 * c - 16 -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
			t[127 - 32 * c - 24 -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
		end
		return t;
	endfunction

	function automatic blk_t next_rk(input blk_t k, input byte_t rc);
		blk_t n;
		logic [31:0] w;
		w = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
		n[127:96] = k[127:96] ^ w;
		n[95:64]  = k[95:64] ^ n[127:96];
		n[63:32]  = k[63:32] ^ n[95:64];
		n[31:0]   = k[31:0] ^ n[63:32];
		return n;
	endfunction

endpackage

[rtl/core/aes128_block_cipher.sv]
// AES-128 ECB block cipher, encrypt or decrypt per block (tuser bit 0 = 1
// decrypts). Fully unrolled: an input register and ten round stages, so a
// block enters every cycle and its result is offered after it has passed
// the input register and all ten round registers; the whole pipeline stalls
// together while a result waits with m_axis_tready low. The key is written
// through cfg_we/cfg_idx/cfg_data (index 0 upper, index 1 lower half); round
// keys are expanded in a registered chain, and s_axis_tready stays low after
// reset and after each key write until a settle count runs out as it refills.
module aes128_block_cipher (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_idx,
	input  logic [63:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,   // block_high, block_low
	input  logic [0:0]   s_axis_tuser,   // command
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata    // result_high, result_low
);

	aes128_pkg::blk_t rk [11];
	logic key_rdy;
	logic en;
	logic vld_s0, dec_s0;
	aes128_pkg::blk_t st_s0;
	logic vld_r [11];
	logic dec_r [11];
	aes128_pkg::blk_t st_r [11];

	aes128_key_sched u_ks (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .rk(rk), .rk_vld(key_rdy)
	);

	// advance when the output slot is free or being taken
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en && key_rdy;

	// input stage: initial add key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s0 <= 1'b0;
		else if (en) vld_s0 <= s_axis_tvalid && key_rdy;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec_s0 <= s_axis_tuser[0];
			st_s0  <= {s_axis_tdata[63:0], s_axis_tdata[127:64]}
				^ (s_axis_tuser[0] ? rk[10] : rk[0]);
		end
	end

	assign vld_r[0] = vld_s0;
	assign dec_r[0] = dec_s0;
	assign st_r[0]  = st_s0;

	// ten round stages; encrypt round r uses rk[r], decrypt uses rk[10-r]
	for (genvar r = 1; r <= 10; r++) begin : g_rnd
		aes128_round u_rnd (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(vld_r[r - 1]), .dec_in(dec_r[r - 1]), .st_in(st_r[r - 1]),
			.key_enc(rk[r]), .key_dec(rk[10 - r]),
			.do_mix(r != 10),
			.vld_s1(vld_r[r]), .dec_s1(dec_r[r]), .st_s1(st_r[r])
		);
	end

	assign m_axis_tvalid = vld_r[10];
	assign m_axis_tdata  = {st_r[10][63:0], st_r[10][127:64]};

endmodule

[rtl/core/aes128_key_sched.sv]
module aes128_key_sched (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_idx,
	input  logic [63:0]           cfg_data,
	output aes128_pkg::blk_t      rk [11],
	output logic                  rk_vld
);

	logic [63:0] key_hi_q, key_lo_q;
	logic [3:0] settle_q;
	aes128_pkg::blk_t rk_q [11];

	// hold the key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				aes128_pkg::REG_KEY_HIGH: key_hi_q <= cfg_data;
				aes128_pkg::REG_KEY_LOW:  key_lo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// count down while the chain below refills after reset or a key write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) settle_q <= aes128_pkg::KeySettle;
		else if (cfg_we) settle_q <= aes128_pkg::KeySettle;
		else if (settle_q != 4'd0) settle_q <= settle_q - 4'd1;
	end

	assign rk_vld = (settle_q == 4'd0);

	// expand one round key per cycle from the previous register
	always_ff @(posedge clk) begin
		rk_q[0] <= {key_hi_q, key_lo_q};
		for (int r = 1; r <= aes128_pkg::NumRounds; r++) begin
			rk_q[r] <= aes128_pkg::next_rk(rk_q[r - 1], aes128_pkg::RCON[r - 1]);
		end
	end

	assign rk = rk_q;

endmodule

[rtl/core/aes128_round.sv]
module aes128_round (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  vld_in,
	input  logic                  dec_in,
	input  aes128_pkg::blk_t      st_in,
	input  aes128_pkg::blk_t      key_enc,
	input  aes128_pkg::blk_t      key_dec,
	input  logic                  do_mix,
	output logic                  vld_s1,
	output logic                  dec_s1,
	output aes128_pkg::blk_t      st_s1
);

	aes128_pkg::blk_t ss, nxt;

	// encrypt: sub/shift, mix, add key; decrypt: sub/shift, add key, mix; no mix when do_mix is low
	always_comb begin
		ss = aes128_pkg::sub_shift(st_in, dec_in);
		if (dec_in) begin
			nxt = ss ^ key_dec;
			if (do_mix) nxt = aes128_pkg::mix(nxt, 1'b1);
		end else begin
			nxt = do_mix ? aes128_pkg::mix(ss, 1'b0) : ss;
			nxt = nxt ^ key_enc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec_s1 <= dec_in;
			st_s1  <= nxt;
		end
	end

endmodule
